### rtl/irpd_pkg.sv
`default_nettype none

package irpd_pkg;

    localparam int TICKS_W = 16;
    localparam int WORD_W  = 48;
    localparam int CNT_W   = 6;
    localparam int PRE_W   = 12;

    // Default frame lengths in bits.
    localparam int SHORT_BITS_DEF   = 32;
    localparam int LONG_BITS_DEF    = 48;
    localparam int UNKNOWN_BITS_DEF = 32;

    // Preamble windows in 100 us ticks; PRE_MIN and PRE_MAX bounds inclusive, the others exclusive.
    localparam logic [TICKS_W-1:0] PRE_MIN       = 16'd300;
    localparam logic [TICKS_W-1:0] PRE_MAX       = 16'd3000;
    localparam logic [TICKS_W-1:0] PRE_SHORT_LO  = 16'd1300;
    localparam logic [TICKS_W-1:0] PRE_SHORT_HI  = 16'd1430;
    localparam logic [TICKS_W-1:0] PRE_REPEAT_LO = 16'd1100;
    localparam logic [TICKS_W-1:0] PRE_REPEAT_HI = 16'd1200;
    localparam logic [TICKS_W-1:0] PRE_LONG_LO   = 16'd510;
    localparam logic [TICKS_W-1:0] PRE_LONG_HI   = 16'd530;

    // Bit windows, bounds exclusive.
    localparam logic [TICKS_W-1:0] BIT_ONE_LO  = 16'd160;
    localparam logic [TICKS_W-1:0] BIT_ONE_HI  = 16'd240;
    localparam logic [TICKS_W-1:0] BIT_ZERO_LO = 16'd60;
    localparam logic [TICKS_W-1:0] BIT_ZERO_HI = 16'd125;

    typedef enum logic [1:0] {
        KIND_IDLE    = 2'd0,
        KIND_SHORT   = 2'd1,
        KIND_LONG    = 2'd2,
        KIND_UNKNOWN = 2'd3
    } t_kind;

    localparam logic [1:0] PROTO_SHORT   = 2'd0;
    localparam logic [1:0] PROTO_LONG    = 2'd1;
    localparam logic [1:0] PROTO_UNKNOWN = 2'd2;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BIT_ERROR = 1'b1;

    typedef struct packed {
        logic in_range;
        logic pre_short;
        logic pre_repeat;
        logic pre_long;
        logic bit_one;
        logic bit_zero;
    } t_window;

    function automatic logic [1:0] protocol_of(input t_kind kind);
        logic [1:0] proto;
        case (kind)
            KIND_LONG:    proto = PROTO_LONG;
            KIND_UNKNOWN: proto = PROTO_UNKNOWN;
            default:      proto = PROTO_SHORT;
        endcase
        return proto;
    endfunction

endpackage

`default_nettype wire

### rtl/irpd_in_if.sv
`default_nettype none

interface irpd_in_if
    import irpd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TICKS_W-1:0] interval_ticks;

    modport source (output valid, output interval_ticks, input ready);
    modport sink   (input valid, input interval_ticks, output ready);
endinterface

`default_nettype wire

### rtl/irpd_out_if.sv
`default_nettype none

interface irpd_out_if
    import irpd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              status;
    logic [1:0]        protocol;
    logic [WORD_W-1:0] command;
    logic              is_repeat;
    logic [PRE_W-1:0]  preamble_ticks;

    modport source (output valid, output status, output protocol, output command,
                    output is_repeat, output preamble_ticks, input ready);
    modport sink   (input valid, input status, input protocol, input command,
                    input is_repeat, input preamble_ticks, output ready);
endinterface

`default_nettype wire

### rtl/irpd_window.sv
`default_nettype none

module irpd_window
    import irpd_pkg::*;
(
    input  wire logic [TICKS_W-1:0] i_ticks,
    output t_window                 o_window
);

    always_comb begin
        o_window.in_range   = (i_ticks >= PRE_MIN) && (i_ticks <= PRE_MAX);
        o_window.pre_short  = (i_ticks > PRE_SHORT_LO) && (i_ticks < PRE_SHORT_HI);
        o_window.pre_repeat = (i_ticks > PRE_REPEAT_LO) && (i_ticks < PRE_REPEAT_HI);
        o_window.pre_long   = (i_ticks > PRE_LONG_LO) && (i_ticks < PRE_LONG_HI);
        o_window.bit_one    = (i_ticks > BIT_ONE_LO) && (i_ticks < BIT_ONE_HI);
        o_window.bit_zero   = (i_ticks > BIT_ZERO_LO) && (i_ticks < BIT_ZERO_HI);
    end

endmodule

`default_nettype wire

### rtl/ir_pulse_distance_decoder.sv
`default_nettype none

// Pulse-distance infrared remote decoder. Each input word is one interval
// between falling edges in 100 us ticks; while idle it is read as a preamble
// (short frame, repeat code, long frame or unknown frame; values outside
// 300..3000 are dropped), and after a frame preamble each interval is one
// data bit, first bit most significant. A word is taken every clock cycle
// unless the input side stalls: it passes an input register, one level of
// window compares and state update, and lands in the result register,
// where the result is held until it is taken.
// While a result waits, one more word is accepted into the input register;
// the input side then stalls until the result is taken, whether or not that
// word produces a result. A bad bit interval reports an error with a zero
// command and returns the decoder to idle. There is no clearing pass after
// reset.
module ir_pulse_distance_decoder
    import irpd_pkg::*;
#(
    parameter int SHORT_FRAME_BITS   = SHORT_BITS_DEF,
    parameter int LONG_FRAME_BITS    = LONG_BITS_DEF,
    parameter int UNKNOWN_FRAME_BITS = UNKNOWN_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    irpd_in_if.sink    i_in,
    irpd_out_if.source o_out
);

    localparam logic [CNT_W-1:0] ShortBits   = CNT_W'(SHORT_FRAME_BITS);
    localparam logic [CNT_W-1:0] LongBits    = CNT_W'(LONG_FRAME_BITS);
    localparam logic [CNT_W-1:0] UnknownBits = CNT_W'(UNKNOWN_FRAME_BITS);

    logic               r_in_valid;
    logic [TICKS_W-1:0] r_in_ticks;

    t_kind              r_kind,      n_kind;
    logic [CNT_W-1:0]   r_needed,    n_needed;
    logic [CNT_W-1:0]   r_received,  n_received;
    logic [WORD_W-1:0]  r_shift,     n_shift;
    logic [WORD_W-1:0]  r_last_word, n_last_word;
    logic [PRE_W-1:0]   r_preamble,  n_preamble;

    logic               r_out_valid;
    logic               r_out_status,    n_out_status;
    logic [1:0]         r_out_protocol,  n_out_protocol;
    logic [WORD_W-1:0]  r_out_command,   n_out_command;
    logic               r_out_is_repeat, n_out_is_repeat;
    logic [PRE_W-1:0]   r_out_preamble,  n_out_preamble;

    logic               advance;
    logic               emit;
    t_window            window;
    logic [WORD_W-1:0]  shifted;
    logic [CNT_W-1:0]   count_inc;

    irpd_window u_window (
        .i_ticks  (r_in_ticks),
        .o_window (window)
    );

    // The held word moves on once the result register is free or being emptied.
    assign advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign shifted   = {r_shift[WORD_W-2:0], window.bit_one};
    assign count_inc = r_received + CNT_W'(1);

    always_comb begin
        n_kind          = r_kind;
        n_needed        = r_needed;
        n_received      = r_received;
        n_shift         = r_shift;
        n_last_word     = r_last_word;
        n_preamble      = r_preamble;
        emit            = 1'b0;
        n_out_status    = STATUS_OK;
        n_out_protocol  = protocol_of(r_kind);
        n_out_command   = '0;
        n_out_is_repeat = 1'b0;
        n_out_preamble  = r_preamble;

        if (advance) begin
            if (r_kind == KIND_IDLE) begin
                if (window.in_range) begin
                    n_received = '0;
                    n_shift    = '0;
                    n_preamble = r_in_ticks[PRE_W-1:0];
                    if (window.pre_short) begin
                        n_kind   = KIND_SHORT;
                        n_needed = ShortBits;
                    end else if (window.pre_repeat) begin
                        emit            = 1'b1;
                        n_out_protocol  = PROTO_SHORT;
                        n_out_command   = r_last_word;
                        n_out_is_repeat = 1'b1;
                        n_out_preamble  = r_in_ticks[PRE_W-1:0];
                        n_needed        = '0;
                        n_preamble      = '0;
                    end else if (window.pre_long) begin
                        n_kind   = KIND_LONG;
                        n_needed = LongBits;
                    end else begin
                        n_kind   = KIND_UNKNOWN;
                        n_needed = UnknownBits;
                    end
                end
            end else if (window.bit_one || window.bit_zero) begin
                if (count_inc >= r_needed) begin
                    emit          = 1'b1;
                    n_out_command = shifted;
                    if (r_kind == KIND_SHORT) begin
                        n_last_word = shifted;
                    end
                    n_kind     = KIND_IDLE;
                    n_needed   = '0;
                    n_received = '0;
                    n_shift    = '0;
                    n_preamble = '0;
                end else begin
                    n_received = count_inc;
                    n_shift    = shifted;
                end
            end else begin
                emit         = 1'b1;
                n_out_status = STATUS_BIT_ERROR;
                n_kind       = KIND_IDLE;
                n_needed     = '0;
                n_received   = '0;
                n_shift      = '0;
                n_preamble   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_kind      <= KIND_IDLE;
            r_needed    <= '0;
            r_received  <= '0;
            r_shift     <= '0;
            r_last_word <= '0;
            r_preamble  <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_kind      <= n_kind;
            r_needed    <= n_needed;
            r_received  <= n_received;
            r_shift     <= n_shift;
            r_last_word <= n_last_word;
            r_preamble  <= n_preamble;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in_ticks <= i_in.interval_ticks;
        end
        if (advance && emit) begin
            r_out_status    <= n_out_status;
            r_out_protocol  <= n_out_protocol;
            r_out_command   <= n_out_command;
            r_out_is_repeat <= n_out_is_repeat;
            r_out_preamble  <= n_out_preamble;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.protocol       = r_out_protocol;
    assign o_out.command        = r_out_command;
    assign o_out.is_repeat      = r_out_is_repeat;
    assign o_out.preamble_ticks = r_out_preamble;

`ifndef SYNTH
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kind == KIND_IDLE |-> r_received == '0 && r_shift == '0)
        else $error("idle decoder holds a partial frame");

    a_count_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kind != KIND_IDLE |-> r_received < r_needed)
        else $error("bit count reached frame length without completing");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == STATUS_BIT_ERROR
            |-> r_out_command == '0 && !r_out_is_repeat)
        else $error("error result carries a command");

    a_repeat_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_is_repeat
            |-> r_out_protocol == PROTO_SHORT && r_out_status == STATUS_OK)
        else $error("repeat result with wrong protocol or status");

    a_stored_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == STATUS_OK && r_out_protocol == PROTO_SHORT
            |-> r_out_command == r_last_word)
        else $error("short frame result differs from stored word");
`endif

endmodule

`default_nettype wire
